// File: hw/rtl/lc3_pkg.sv
// Shared types, constants and the contrast function of the 3x3 local contrast block.
package lc3_pkg;

  // Luminance word and register width
  localparam int unsigned LUM_W   = 8;
  localparam int unsigned WIDTH_W = 11;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 11'd1024;

  // Q16 luminance weights, they sum to exactly 65536
  localparam logic [15:0] COEF_R = 16'd13933;
  localparam logic [15:0] COEF_G = 16'd46871;
  localparam logic [15:0] COEF_B = 16'd4732;

  // Result queue: depth is a power of two so the pointers wrap by themselves
  localparam int unsigned OQ_DEPTH  = 8;
  localparam int unsigned OQ_PTR_W  = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CNT_W  = $clog2(OQ_DEPTH + 1);
  localparam int unsigned OQ_NEED_W = OQ_CNT_W + 1;

  // One window column: top, middle and bottom luminance
  typedef struct packed {
    logic [LUM_W-1:0] top;
    logic [LUM_W-1:0] mid;
    logic [LUM_W-1:0] bot;
  } col_t;

  // One result word
  typedef struct packed {
    logic [LUM_W-1:0] contrast;
    logic             last_of_run;
    logic             frame_end;
  } res_t;

  // Up to two result words pushed in one cycle, lo first
  typedef struct packed {
    logic lo_v;
    logic hi_v;
    res_t lo;
    res_t hi;
  } push_t;

  // floor(|8*centre - sum of 8 neighbours| / 8)
  function automatic logic [LUM_W-1:0] contrast_of(input col_t l, input col_t c,
                                                   input col_t r);
    logic [LUM_W+3:0] sum_all;
    logic [LUM_W+2:0] nb;
    logic [LUM_W+2:0] eight;
    logic [LUM_W+2:0] d;
    sum_all = (LUM_W+4)'(l.top) + (LUM_W+4)'(l.mid) + (LUM_W+4)'(l.bot)
            + (LUM_W+4)'(c.top) + (LUM_W+4)'(c.mid) + (LUM_W+4)'(c.bot)
            + (LUM_W+4)'(r.top) + (LUM_W+4)'(r.mid) + (LUM_W+4)'(r.bot);
    nb    = (LUM_W+3)'(sum_all - (LUM_W+4)'(c.mid));
    eight = {c.mid, 3'b000};
    d     = (eight >= nb) ? (eight - nb) : (nb - eight);
    return d[LUM_W+2:3];
  endfunction

endpackage

// File: hw/rtl/local_contrast_3x3.sv
// Top level of the streaming 3x3 local contrast block on RGB luminance.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+----------------------------------------
//  in       | in_valid_i / in_stall_o  | kind_i, red_i, green_i, blue_i
//  out      | out_valid_o / out_stall_i| contrast_o, last_of_run_o, frame_end_o
//  config   | psel/penable/pwrite      | paddr, pwdata, prdata (image_width)
//
// One pixel word a cycle while in_stall_o is low; the line stores take one read and
// one write per cycle. A result passes through store read, luminance and window
// update with write back, then contrast into the result queue, before it leaves.
// in_stall_o rises only when the 8-entry result queue cannot hold the results of the
// words in flight plus one more. The line stores need no clearing pass after reset.
// A write of image_width restarts the frame at the first row.
module local_contrast_3x3 import lc3_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // pixel words in
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              kind_i,
  input  logic [7:0]        red_i,
  input  logic [7:0]        green_i,
  input  logic [7:0]        blue_i,
  // result words out
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [LUM_W-1:0]  contrast_o,
  output logic              last_of_run_o,
  output logic              frame_end_o,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // Row phase codes
  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_BODY  = 2'd1;
  localparam logic [1:0] PH_FLUSH = 2'd2;

  localparam logic       KIND_FLUSH       = 1'b1;
  localparam logic [1:0] ADDR_IMAGE_WIDTH = 2'd0;

  function automatic logic [COL_W-1:0] last_col_of(input logic [WIDTH_W-1:0] v);
    if (v == '0) begin
      return '0;
    end else if (32'(v) > MAX_WIDTH) begin
      return COL_W'(MAX_WIDTH - 1);
    end else begin
      return COL_W'(v - WIDTH_W'(1));
    end
  endfunction

  // Register and frame position
  logic [WIDTH_W-1:0] image_width_q;
  logic [COL_W-1:0]   last_col_q;
  logic [COL_W-1:0]   col_q, col_d;
  logic [1:0]         phase_q, phase_d;
  logic               cfg_wr;

  // Accept stage
  logic               in_acc, is_flush, start_flush, drop, act, at_last;
  logic [1:0]         eff_phase;
  logic               haz_d;

  // Store read stage
  logic               s1_v_q;
  logic [1:0]         s1_phase_q;
  logic [COL_W-1:0]   s1_col_q;
  logic               s1_first_q, s1_last_q, s1_haz_q;
  logic [21:0]        s1_pr_q;
  logic [23:0]        s1_pg_q;
  logic [20:0]        s1_pb_q;
  logic [LUM_W-1:0]   older_rd, prev_rd;
  logic [LUM_W-1:0]   top, mid, lum;
  logic [23:0]        lum_sum;
  logic               s1_wr, s1_out;
  logic [LUM_W-1:0]   older_wd;
  logic [LUM_W-1:0]   fwd_older_q, fwd_prev_q;
  col_t               new_col;
  col_t               win_q [3];

  // Contrast stage
  logic               s2_v_q, s2_mid_q, s2_edge_q, s2_fend_q;
  logic [LUM_W-1:0]   res_mid, res_edge;
  push_t              push;
  logic [OQ_CNT_W-1:0] level;
  logic [OQ_NEED_W-1:0] need;
  res_t               out_res;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr == ADDR_IMAGE_WIDTH) ? 32'(image_width_q) : '0;

  // Hold back while the queue lacks room for the words in flight
  assign need = OQ_NEED_W'(level) + OQ_NEED_W'({s1_v_q, 1'b0})
              + OQ_NEED_W'({s2_v_q, 1'b0}) + OQ_NEED_W'(2);
  assign in_stall_o = need > OQ_NEED_W'(OQ_DEPTH);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Classify the incoming word
  always_comb begin
    is_flush    = (kind_i == KIND_FLUSH);
    at_last     = (col_q == last_col_q);
    start_flush = is_flush && (phase_q == PH_BODY) && (col_q == '0);
    drop        = is_flush && (phase_q != PH_FLUSH) && !start_flush;
    eff_phase   = start_flush ? PH_FLUSH : phase_q;
    act         = in_acc && !drop;
    s1_wr       = s1_v_q && (s1_phase_q != PH_FLUSH);
    haz_d       = s1_wr && (s1_col_q == col_q);
    if (at_last) begin
      col_d   = '0;
      phase_d = (eff_phase == PH_FLUSH) ? PH_FIRST : PH_BODY;
    end else begin
      col_d   = col_q + COL_W'(1);
      phase_d = eff_phase;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q <= WIDTH_RESET;
      last_col_q    <= last_col_of(WIDTH_RESET);
      col_q         <= '0;
      phase_q       <= PH_FIRST;
      s1_v_q        <= 1'b0;
    end else begin
      s1_v_q <= act;
      if (cfg_wr) begin
        image_width_q <= pwdata[WIDTH_W-1:0];
        last_col_q    <= last_col_of(pwdata[WIDTH_W-1:0]);
        col_q         <= '0;
        phase_q       <= PH_FIRST;
      end else if (act) begin
        col_q   <= col_d;
        phase_q <= phase_d;
      end
    end
  end

  // Capture the word's control and the weighted channels
  always_ff @(posedge clk_i) begin
    if (act) begin
      s1_phase_q <= eff_phase;
      s1_col_q   <= col_q;
      s1_first_q <= (col_q == '0);
      s1_last_q  <= at_last;
      s1_haz_q   <= haz_d;
      s1_pr_q    <= 22'(red_i * COEF_R[13:0]);
      s1_pg_q    <= 24'(green_i * COEF_G);
      s1_pb_q    <= 21'(blue_i * COEF_B[12:0]);
    end
  end

  // Line stores, read at the current column every cycle
  lc3_ram #(.WIDTH(LUM_W), .DEPTH(MAX_WIDTH)) u_older (
    .clk_i   (clk_i),
    .we_i    (s1_wr),
    .waddr_i (s1_col_q),
    .wdata_i (older_wd),
    .raddr_i (col_q),
    .rdata_o (older_rd)
  );

  lc3_ram #(.WIDTH(LUM_W), .DEPTH(MAX_WIDTH)) u_prev (
    .clk_i   (clk_i),
    .we_i    (s1_wr),
    .waddr_i (s1_col_q),
    .wdata_i (lum),
    .raddr_i (col_q),
    .rdata_o (prev_rd)
  );

  // Forward the last write when it hit the entry just read
  always_comb begin
    top      = s1_haz_q ? fwd_older_q : older_rd;
    mid      = s1_haz_q ? fwd_prev_q  : prev_rd;
    lum_sum  = 24'(s1_pr_q) + s1_pg_q + 24'(s1_pb_q);
    lum      = (s1_phase_q == PH_FLUSH) ? mid : lum_sum[23:16];
    older_wd = (s1_phase_q == PH_BODY) ? mid : lum;
    new_col  = '{top: top, mid: mid, bot: lum};
    s1_out   = (s1_phase_q == PH_BODY) || (s1_phase_q == PH_FLUSH);
  end

  always_ff @(posedge clk_i) begin
    if (s1_wr) begin
      fwd_older_q <= older_wd;
      fwd_prev_q  <= lum;
    end
  end

  // Shift the window, or replicate the column at the row start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q[0] <= '0;
      win_q[1] <= '0;
      win_q[2] <= '0;
    end else if (s1_v_q && s1_out) begin
      if (s1_first_q) begin
        win_q[0] <= new_col;
        win_q[1] <= new_col;
      end else begin
        win_q[0] <= win_q[1];
        win_q[1] <= win_q[2];
      end
      win_q[2] <= new_col;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q    <= 1'b0;
      s2_mid_q  <= 1'b0;
      s2_edge_q <= 1'b0;
      s2_fend_q <= 1'b0;
    end else begin
      s2_v_q    <= s1_v_q;
      s2_mid_q  <= s1_out && !s1_first_q;
      s2_edge_q <= s1_out && s1_last_q;
      s2_fend_q <= (s1_phase_q == PH_FLUSH);
    end
  end

  // Contrast of the centre pixel and of the right-edge pixel
  always_comb begin
    res_mid  = contrast_of(win_q[0], win_q[1], win_q[2]);
    res_edge = contrast_of(win_q[1], win_q[2], win_q[2]);
    push.lo_v = s2_v_q && (s2_mid_q || s2_edge_q);
    push.hi_v = s2_v_q && s2_mid_q && s2_edge_q;
    push.hi   = '{contrast: res_edge, last_of_run: 1'b1, frame_end: s2_fend_q};
    if (s2_mid_q) begin
      push.lo = '{contrast: res_mid, last_of_run: !s2_edge_q, frame_end: 1'b0};
    end else begin
      push.lo = push.hi;
    end
  end

  lc3_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .level_o     (level),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res)
  );

  assign contrast_o    = out_res.contrast;
  assign last_of_run_o = out_res.last_of_run;
  assign frame_end_o   = out_res.frame_end;

  a_col_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act && at_last) |=> (col_q == '0))
    else $error("column did not wrap after the last column");

  a_first_row_keeps_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && s1_phase_q == PH_FIRST) |=>
      ($stable(win_q[0]) && $stable(win_q[1]) && $stable(win_q[2])))
    else $error("window changed during the first row");

  a_stage_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |=> s2_v_q)
    else $error("word lost between store stage and contrast stage");

endmodule

// File: hw/rtl/lc3_ram.sv
// Generic single-write, single-read RAM with registered read data (read-old on collision).
module lc3_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/lc3_outq.sv
// Result queue: takes up to two result words a cycle, hands out one while not stalled.
module lc3_outq import lc3_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  push_t               push_i,
  output logic [OQ_CNT_W-1:0] level_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output res_t                out_res_o
);

  res_t                ent_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] head_q, head_d;
  logic [OQ_PTR_W-1:0] tail_q, tail_d;
  logic [OQ_CNT_W-1:0] level_q, level_d;
  logic [OQ_CNT_W-1:0] npush;
  logic                pop;

  assign pop   = out_valid_o && !out_stall_i;
  assign npush = OQ_CNT_W'(push_i.lo_v) + OQ_CNT_W'(push_i.hi_v);

  // Advance pointers and fill level
  always_comb begin
    head_d  = head_q + OQ_PTR_W'(pop);
    tail_d  = tail_q + OQ_PTR_W'(npush);
    level_d = level_q + npush - OQ_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      level_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      level_q <= level_d;
    end
  end

  // Store the words at the tail
  always_ff @(posedge clk_i) begin
    if (push_i.lo_v) begin
      ent_q[tail_q] <= push_i.lo;
    end
    if (push_i.hi_v) begin
      ent_q[tail_q + OQ_PTR_W'(1)] <= push_i.hi;
    end
  end

  assign level_o     = level_q;
  assign out_valid_o = (level_q != '0);
  assign out_res_o   = ent_q[head_q];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (OQ_NEED_W'(level_q) + OQ_NEED_W'(npush)) <= OQ_NEED_W'(OQ_DEPTH))
    else $error("result queue overflow");

  a_hi_needs_lo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.hi_v |-> push_i.lo_v)
    else $error("second word pushed without first");

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && npush == '0) |=> (level_q == $past(level_q) - OQ_CNT_W'(1)))
    else $error("pop did not lower the level");

endmodule
